[rtl/core/pibp_pkg.sv]
// Shared types and constants of the palette index bitplane packer.
package pibp_pkg;

  localparam int unsigned COLOUR_W = 6;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned PLANES   = 4;
  localparam int unsigned LINE_PIXELS = 8;
  localparam int unsigned WORD_W   = 32;
  localparam logic [INDEX_W-1:0] OVERFLOW_INDEX = 5'd16;
  localparam logic [7:0] CHANNEL_TOP = 8'hc0;

  localparam logic OP_PIXEL  = 1'b0;
  localparam logic OP_APPEND = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  // Control broadcast to every palette cell
  typedef struct packed {
    logic                wr_en;
    logic                sel;
    logic [COLOUR_W-1:0] wr_colour;
    logic [COLOUR_W-1:0] cmp_colour;
  } cell_ctrl_t;

  // What the plane accumulators give back for the current pixel
  typedef struct packed {
    logic [WORD_W-1:0] line_word;
    logic              line_done;
  } plane_res_t;

endpackage

[rtl/core/palette_index_bitplane_packer.sv]
// Top level of the palette index bitplane packer.
// Each accepted word is first captured; once the output slot is free, the row of
// palette cells compares the colour against the filled entries of the selected palette,
// a first-hit link through the row picks the lowest match, and the palette and the
// bitplane accumulators update. A new word is taken only once the last one is
// resolved and has been handed to the output register. The result sits in an output
// register, so the next word is accepted while it waits. in_tuser carries the opcode
// (bit 0, 1 = append direct colour) and the palette select (bit 1, 1 = sprite).
// out_tlast marks the word that closes a line of eight and carries line_word.
module palette_index_bitplane_packer #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // sprite_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // red[7:0], green[15:8], blue[23:16], alpha[31:24],
                                     // direct_colour[37:32], zero
  input  logic [1:0]  in_tuser,      // opcode[0], palette_select[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,     // palette_index[4:0], line_word[36:5], zero
  output logic        out_tlast,     // line_done
  output logic        out_tuser      // overflow
);

  localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);

  pibp_pkg::state_t state_r, state_nxt;

  logic        sprite_mode_r;
  logic [39:0] cmd_data_r;
  logic [1:0]  cmd_user_r;
  logic [CNT_W-1:0] bg_cnt_r, bg_cnt_nxt;
  logic [CNT_W-1:0] spr_cnt_r, spr_cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  out_index_r;
  logic [31:0] out_word_r;
  logic        out_done_r;
  logic        out_ovf_r;

  logic        opcode, sel, opaque, work, out_free, found, full, need_append, append_ok;
  logic [pibp_pkg::COLOUR_W-1:0] pixel_colour;
  logic [CNT_W-1:0] cnt_sel;
  logic [pibp_pkg::INDEX_W-1:0] hit_index, index;
  pibp_pkg::cell_ctrl_t ctrl;
  pibp_pkg::plane_res_t plane_res;
  logic [PALETTE_DEPTH:0]   found_link;
  logic [PALETTE_DEPTH-1:0] take;
  logic [PALETTE_DEPTH-1:0] cmp_en;
  logic [PALETTE_DEPTH-1:0] wr_sel;

  assign opcode   = cmd_user_r[0];
  assign sel      = cmd_user_r[1];
  assign opaque   = (cmd_data_r[31:24] != 8'd0);
  assign out_free = !out_valid_r || out_tready;
  assign work     = (state_r == pibp_pkg::ST_BUSY) && out_free;
  assign cnt_sel  = sel ? spr_cnt_r : bg_cnt_r;
  assign full     = (cnt_sel == CNT_W'(PALETTE_DEPTH));

  // blue, green, red top bits from the high end down
  assign pixel_colour = {cmd_data_r[23:22], cmd_data_r[15:14], cmd_data_r[7:6]};

  // Row of palette cells
  assign found_link[0] = 1'b0;

  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] SLOT = CNT_W'(i);

    // skip entry 0 in sprite mode, and entries not yet filled
    assign cmp_en[i] = (opcode == pibp_pkg::OP_PIXEL) && opaque && (SLOT < cnt_sel)
                       && !(sprite_mode_r && (i == 0));
    assign wr_sel[i] = (SLOT == cnt_sel);

    pibp_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .wr_sel    (wr_sel[i]),
      .cmp_en    (cmp_en[i]),
      .found_in  (found_link[i]),
      .found_out (found_link[i+1]),
      .take      (take[i])
    );
  end

  assign found = found_link[PALETTE_DEPTH];

  always_comb begin
    hit_index = '0;
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      if (take[i]) begin
        hit_index = hit_index | pibp_pkg::INDEX_W'(i);
      end
    end
  end

  always_comb begin
    need_append = (opcode == pibp_pkg::OP_APPEND) || (opaque && !found);
    append_ok   = need_append && !full;

    if (need_append) begin
      index = full ? pibp_pkg::OVERFLOW_INDEX : pibp_pkg::INDEX_W'(cnt_sel);
    end else if (found) begin
      index = hit_index;
    end else begin
      index = '0;
    end

    ctrl.wr_en      = work && append_ok;
    ctrl.sel        = sel;
    ctrl.wr_colour  = (opcode == pibp_pkg::OP_APPEND) ? cmd_data_r[37:32] : pixel_colour;
    ctrl.cmp_colour = pixel_colour;

    bg_cnt_nxt  = bg_cnt_r;
    spr_cnt_nxt = spr_cnt_r;
    if (work && append_ok) begin
      if (sel) begin
        spr_cnt_nxt = spr_cnt_r + CNT_W'(1);
      end else begin
        bg_cnt_nxt = bg_cnt_r + CNT_W'(1);
      end
    end
  end

  pibp_planes u_planes (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (work && (opcode == pibp_pkg::OP_PIXEL)),
    .plane_bits (index[pibp_pkg::PLANES-1:0]),
    .res        (plane_res)
  );

  // Control: capture a word, then resolve it once the output slot is free
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    case (state_r)
      pibp_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = pibp_pkg::ST_BUSY;
        end
      end
      pibp_pkg::ST_BUSY: begin
        if (out_free) begin
          state_nxt     = pibp_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = pibp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pibp_pkg::ST_IDLE;
      sprite_mode_r <= 1'b0;
      bg_cnt_r      <= '0;
      spr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bg_cnt_r    <= bg_cnt_nxt;
      spr_cnt_r   <= spr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        sprite_mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_data_r <= in_tdata;
      cmd_user_r <= in_tuser;
    end
    if (work) begin
      out_index_r <= index;
      out_word_r  <= plane_res.line_word;
      out_done_r  <= plane_res.line_done;
      out_ovf_r   <= need_append && full;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_word_r, out_index_r};
  assign out_tlast  = out_done_r;
  assign out_tuser  = out_ovf_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (bg_cnt_r <= CNT_W'(PALETTE_DEPTH)) && (spr_cnt_r <= CNT_W'(PALETTE_DEPTH)))
    else $error("palette count beyond depth");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(take))
    else $error("more than one cell took the colour");

  a_ovf_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[4:0] == pibp_pkg::OVERFLOW_INDEX)
    else $error("overflow without overflow index");

  a_word_only_on_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[36:5] == 32'd0)
    else $error("line word set without line end");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !work |=> $stable(bg_cnt_r) && $stable(spr_cnt_r))
    else $error("palette count moved while idle");

endmodule

[rtl/core/pibp_cell.sv]
// One palette cell: a background and a sprite entry, a compare and a first-hit link.
module pibp_cell (
  input  logic                   clk,
  input  pibp_pkg::cell_ctrl_t   ctrl,
  input  logic                   wr_sel,
  input  logic                   cmp_en,
  input  logic                   found_in,
  output logic                   found_out,
  output logic                   take
);

  logic [pibp_pkg::COLOUR_W-1:0] bg_entry_r;
  logic [pibp_pkg::COLOUR_W-1:0] spr_entry_r;
  logic [pibp_pkg::COLOUR_W-1:0] entry;
  logic                          hit;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && wr_sel) begin
      if (ctrl.sel) begin
        spr_entry_r <= ctrl.wr_colour;
      end else begin
        bg_entry_r <= ctrl.wr_colour;
      end
    end
  end

  always_comb begin
    entry     = ctrl.sel ? spr_entry_r : bg_entry_r;
    hit       = cmp_en && (entry == ctrl.cmp_colour);
    // pass the hit on; only the first cell that matches takes it
    take      = hit && !found_in;
    found_out = found_in || hit;
  end

endmodule

[rtl/core/pibp_planes.sv]
// Bitplane accumulators: shift one index per pixel into four plane bytes.
module pibp_planes (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [pibp_pkg::PLANES-1:0] plane_bits,
  output pibp_pkg::plane_res_t       res
);

  logic [2:0] pos_r;
  logic [2:0] pos_nxt;
  logic [7:0] acc_r   [pibp_pkg::PLANES];
  logic [7:0] acc_nxt [pibp_pkg::PLANES];
  logic [7:0] merged  [pibp_pkg::PLANES];
  logic       last;

  always_comb begin
    last = (pos_r == 3'(pibp_pkg::LINE_PIXELS - 1));
    for (int p = 0; p < pibp_pkg::PLANES; p++) begin
      merged[p]  = acc_r[p] | (8'(plane_bits[p]) << (3'd7 - pos_r));
      acc_nxt[p] = acc_r[p];
    end
    pos_nxt = pos_r;
    res.line_word = '0;
    res.line_done = 1'b0;
    if (step) begin
      if (last) begin
        res.line_word = {merged[3], merged[2], merged[1], merged[0]};
        res.line_done = 1'b1;
        pos_nxt = '0;
        for (int p = 0; p < pibp_pkg::PLANES; p++) begin
          acc_nxt[p] = '0;
        end
      end else begin
        pos_nxt = pos_r + 3'd1;
        for (int p = 0; p < pibp_pkg::PLANES; p++) begin
          acc_nxt[p] = merged[p];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int p = 0; p < pibp_pkg::PLANES; p++) begin
        acc_r[p] <= '0;
      end
    end else begin
      pos_r <= pos_nxt;
      for (int p = 0; p < pibp_pkg::PLANES; p++) begin
        acc_r[p] <= acc_nxt[p];
      end
    end
  end

endmodule
